FILE: hdl/trvl_pkg.sv
package trvl_pkg;

    localparam int COORD_W    = 40;
    localparam int EXP_W      = 6;
    localparam int DEPTH_W    = 6;
    localparam int ROOT_W     = 6;
    localparam int PATH_W     = 116;
    localparam int FAULT_W    = 2;
    localparam int ROOT_COUNT = 12;
    localparam int LEN_W      = 18;

    localparam logic [FAULT_W-1:0] FAULT_OK    = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_ROOT  = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_DEPTH = 2'd2;

    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_pt;

    typedef struct packed {
        logic [3:0]         root;
        logic [DEPTH_W-1:0] depth;
        logic [PATH_W-1:0]  path;
        logic [FAULT_W-1:0] fault;
    } t_job;

    localparam logic [3:0] ROOT_CORNERS [ROOT_COUNT][4] = '{
        '{4'd0, 4'd2, 4'd3, 4'd8}, '{4'd0, 4'd3, 4'd1, 4'd8},
        '{4'd4, 4'd5, 4'd7, 4'd8}, '{4'd4, 4'd7, 4'd6, 4'd8},
        '{4'd0, 4'd1, 4'd5, 4'd8}, '{4'd0, 4'd5, 4'd4, 4'd8},
        '{4'd2, 4'd6, 4'd7, 4'd8}, '{4'd2, 4'd7, 4'd3, 4'd8},
        '{4'd0, 4'd4, 4'd6, 4'd8}, '{4'd0, 4'd6, 4'd2, 4'd8},
        '{4'd1, 4'd3, 4'd7, 4'd8}, '{4'd1, 4'd7, 4'd5, 4'd8}
    };

    localparam logic [1:0] LATTICE [9][3] = '{
        '{2'd0, 2'd0, 2'd0}, '{2'd2, 2'd0, 2'd0}, '{2'd0, 2'd2, 2'd0},
        '{2'd2, 2'd2, 2'd0}, '{2'd0, 2'd0, 2'd2}, '{2'd2, 2'd0, 2'd2},
        '{2'd0, 2'd2, 2'd2}, '{2'd2, 2'd2, 2'd2}, '{2'd1, 2'd1, 2'd1}
    };

    localparam logic [2:0] DIAG_PAIRS [3][2] = '{
        '{3'd0, 3'd5}, '{3'd1, 3'd4}, '{3'd2, 3'd3}
    };

    localparam logic [2:0] RINGS [3][4] = '{
        '{3'd1, 3'd2, 3'd4, 3'd3}, '{3'd0, 3'd2, 3'd5, 3'd3}, '{3'd0, 3'd1, 3'd5, 3'd4}
    };

    function automatic t_pt root_point(input logic [3:0] root, input logic [1:0] c);
        t_pt        p;
        logic [3:0] v;
        v   = ROOT_CORNERS[root][c];
        p.x = t_coord'(LATTICE[v][0]);
        p.y = t_coord'(LATTICE[v][1]);
        p.z = t_coord'(LATTICE[v][2]);
        return p;
    endfunction

endpackage

FILE: hdl/trvl_front.sv
module trvl_front #(
    parameter int MAX_DEPTH = 38
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [trvl_pkg::ROOT_W-1:0]   i_root,
    input  logic [trvl_pkg::DEPTH_W-1:0]  i_depth,
    input  logic [trvl_pkg::PATH_W-1:0]   i_path,
    output trvl_pkg::t_job                o_job,
    output logic                          o_job_valid,
    input  logic                          i_job_pop
);

    trvl_pkg::t_job r_q [2];
    trvl_pkg::t_job w_job;
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           w_push;

    // classify: bad root first, then depth
    always_comb begin
        w_job.root  = i_root[3:0];
        w_job.depth = i_depth;
        w_job.path  = i_path;
        if (i_root >= trvl_pkg::ROOT_W'(trvl_pkg::ROOT_COUNT)) begin
            w_job.fault = trvl_pkg::FAULT_ROOT;
        end else if (i_depth > trvl_pkg::DEPTH_W'(MAX_DEPTH)) begin
            w_job.fault = trvl_pkg::FAULT_DEPTH;
        end else begin
            w_job.fault = trvl_pkg::FAULT_OK;
        end
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_job_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_job_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

endmodule

FILE: hdl/trvl_back.sv
module trvl_back #(
    parameter int MAX_DEPTH = 38
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  trvl_pkg::t_job                i_job,
    input  logic                          i_job_valid,
    output logic                          o_job_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_corner,
    output trvl_pkg::t_coord              o_x,
    output trvl_pkg::t_coord              o_y,
    output trvl_pkg::t_coord              o_z,
    output logic [trvl_pkg::EXP_W-1:0]    o_exp,
    output logic [trvl_pkg::FAULT_W-1:0]  o_fault,
    output logic                          o_last
);

    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int REM_W = $clog2(MAX_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LEVEL = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]                   r_state;
    trvl_pkg::t_pt                r_g [4];
    logic [3*MAX_DEPTH-1:0]       r_path;
    logic [REM_W-1:0]             r_rem;
    logic [trvl_pkg::DEPTH_W-1:0] r_depth;
    logic [1:0]                   r_corner;
    trvl_pkg::t_coord             r_rx;
    trvl_pkg::t_coord             r_ry;
    trvl_pkg::t_coord             r_rz;
    logic [trvl_pkg::EXP_W-1:0]   r_re;

    trvl_pkg::t_pt                w_m [6];
    trvl_pkg::t_pt                w_nx [4];
    logic [trvl_pkg::LEN_W-1:0]   w_len [3];
    logic [trvl_pkg::LEN_W-1:0]   w_blen;
    logic [1:0]                   w_best;
    logic [REM_W-1:0]             w_rem_m1;
    logic [2:0]                   w_digit;
    logic [1:0]                   w_r;
    logic [7:0]                   w_low;
    logic [3:0]                   w_tz;
    logic [3:0]                   w_k;
    logic                         w_done;
    logic                         w_out_free;
    logic                         w_start;

    function automatic trvl_pkg::t_pt add_pt(input trvl_pkg::t_pt a, input trvl_pkg::t_pt b);
        trvl_pkg::t_pt s;
        s.x = a.x + b.x;
        s.y = a.y + b.y;
        s.z = a.z + b.z;
        return s;
    endfunction

    function automatic trvl_pkg::t_pt dbl_pt(input trvl_pkg::t_pt a);
        trvl_pkg::t_pt s;
        s.x = {a.x[trvl_pkg::COORD_W-2:0], 1'b0};
        s.y = {a.y[trvl_pkg::COORD_W-2:0], 1'b0};
        s.z = {a.z[trvl_pkg::COORD_W-2:0], 1'b0};
        return s;
    endfunction

    function automatic logic [15:0] sq8(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        logic [7:0] m;
        d = a - b;
        m = d[7] ? (8'd0 - d) : d;
        return 16'(m * m);
    endfunction

    // Diagonal vectors stay a few lattice units long at every level, so the
    // low byte of each coordinate settles the exact squared length.
    function automatic logic [trvl_pkg::LEN_W-1:0] dist2(input trvl_pkg::t_pt a,
                                                        input trvl_pkg::t_pt b);
        logic [trvl_pkg::LEN_W-1:0] s;
        s = trvl_pkg::LEN_W'(sq8(a.x[7:0], b.x[7:0]))
          + trvl_pkg::LEN_W'(sq8(a.y[7:0], b.y[7:0]))
          + trvl_pkg::LEN_W'(sq8(a.z[7:0], b.z[7:0]));
        return s;
    endfunction

    // one subdivision level
    always_comb begin
        w_m[0] = add_pt(r_g[0], r_g[1]);
        w_m[1] = add_pt(r_g[0], r_g[2]);
        w_m[2] = add_pt(r_g[0], r_g[3]);
        w_m[3] = add_pt(r_g[1], r_g[2]);
        w_m[4] = add_pt(r_g[1], r_g[3]);
        w_m[5] = add_pt(r_g[2], r_g[3]);
        w_len[0] = dist2(w_m[0], w_m[5]);
        w_len[1] = dist2(w_m[1], w_m[4]);
        w_len[2] = dist2(w_m[2], w_m[3]);
        w_best = 2'd0;
        w_blen = w_len[0];
        if (w_len[1] < w_blen) begin
            w_best = 2'd1;
            w_blen = w_len[1];
        end
        if (w_len[2] < w_blen) begin
            w_best = 2'd2;
        end
        w_rem_m1 = r_rem - 1'b1;
        w_digit  = r_path[3*w_rem_m1[IDX_W-1:0] +: 3];
        w_r      = w_digit[1:0];
        unique case (w_digit)
            3'd0: begin
                w_nx[0] = dbl_pt(r_g[0]); w_nx[1] = w_m[0];
                w_nx[2] = w_m[1];         w_nx[3] = w_m[2];
            end
            3'd1: begin
                w_nx[0] = dbl_pt(r_g[1]); w_nx[1] = w_m[0];
                w_nx[2] = w_m[3];         w_nx[3] = w_m[4];
            end
            3'd2: begin
                w_nx[0] = dbl_pt(r_g[2]); w_nx[1] = w_m[1];
                w_nx[2] = w_m[3];         w_nx[3] = w_m[5];
            end
            3'd3: begin
                w_nx[0] = dbl_pt(r_g[3]); w_nx[1] = w_m[2];
                w_nx[2] = w_m[4];         w_nx[3] = w_m[5];
            end
            default: begin
                w_nx[0] = w_m[trvl_pkg::DIAG_PAIRS[w_best][0]];
                w_nx[1] = w_m[trvl_pkg::RINGS[w_best][w_r]];
                w_nx[2] = w_m[trvl_pkg::RINGS[w_best][w_r + 2'd1]];
                w_nx[3] = w_m[trvl_pkg::DIAG_PAIRS[w_best][1]];
            end
        endcase
    end

    // reduction step: strip up to eight common factors of two per cycle
    always_comb begin
        w_low = r_rx[7:0] | r_ry[7:0] | r_rz[7:0];
        w_tz  = 4'd8;
        for (int i = 7; i >= 0; i--) begin
            if (w_low[i]) begin
                w_tz = 4'(i);
            end
        end
        w_k    = (r_re < {2'b0, w_tz}) ? r_re[3:0] : w_tz;
        w_done = (w_tz != 4'd8) || (r_re <= {2'b0, w_tz});
    end

    assign w_out_free = !o_valid || i_ready;
    assign o_job_pop  = (r_state == S_IDLE) && i_job_valid
                      && ((i_job.fault == trvl_pkg::FAULT_OK) || w_out_free);
    assign w_start    = o_job_pop && (i_job.fault == trvl_pkg::FAULT_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if ((o_job_pop && !w_start) || ((r_state == S_OUT) && w_out_free)) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_state <= (i_job.depth == '0) ? S_LOAD : S_LEVEL;
                    end
                end
                S_LEVEL: begin
                    if (r_rem == REM_W'(1)) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (w_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= (r_corner == 2'd3) ? S_IDLE : S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            for (int c = 0; c < 4; c++) begin
                r_g[c] <= trvl_pkg::root_point(i_job.root, 2'(c));
            end
            r_path   <= i_job.path[3*MAX_DEPTH-1:0];
            r_rem    <= i_job.depth[REM_W-1:0];
            r_depth  <= i_job.depth;
            r_corner <= 2'd0;
        end
        if (o_job_pop && !w_start) begin
            o_corner <= 2'd0;
            o_x      <= '0;
            o_y      <= '0;
            o_z      <= '0;
            o_exp    <= '0;
            o_fault  <= i_job.fault;
            o_last   <= 1'b1;
        end
        if (r_state == S_LEVEL) begin
            for (int c = 0; c < 4; c++) begin
                r_g[c] <= w_nx[c];
            end
            r_rem <= w_rem_m1;
        end
        if (r_state == S_LOAD) begin
            r_rx <= r_g[r_corner].x;
            r_ry <= r_g[r_corner].y;
            r_rz <= r_g[r_corner].z;
            r_re <= r_depth + 1'b1;
        end
        if (r_state == S_SHIFT) begin
            r_rx <= r_rx >> w_k;
            r_ry <= r_ry >> w_k;
            r_rz <= r_rz >> w_k;
            r_re <= r_re - {2'b0, w_k};
        end
        if ((r_state == S_OUT) && w_out_free) begin
            o_corner <= r_corner;
            o_x      <= r_rx;
            o_y      <= r_ry;
            o_z      <= r_rz;
            o_exp    <= r_re;
            o_fault  <= trvl_pkg::FAULT_OK;
            o_last   <= (r_corner == 2'd3);
            r_corner <= r_corner + 2'd1;
        end
    end

endmodule

FILE: hdl/tet_red_refine_vertex_locator.sv
// Sequence: an address is registered into the queue, then the level engine walks depth levels
// of subdivision (one level per cycle), then each corner gets a load step, one or more
// reduction steps and an output step; a bad address gives its single result once the output is free.
// The back end takes the next address only after the last corner of the current one is out.
// Reset: synchronous, active low; clears the queue, the sequencer and the output valid.
module tet_red_refine_vertex_locator #(
    parameter int MAX_DEPTH = 38
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // root_index[5:0], level_count[11:6], path_upper[63:12], path_lower[127:64]
    input  logic [127:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // coord_x[39:0], coord_y[79:40], coord_z[119:80], exponent[125:120], zero[127:126]
    output logic [127:0] o_m_axis_tdata,
    // corner[1:0], fault[3:2]
    output logic [3:0]   o_m_axis_tuser,
    output logic         o_m_axis_tlast
);

    trvl_pkg::t_job                w_job;
    logic                          w_job_valid;
    logic                          w_job_pop;
    logic [1:0]                    w_corner;
    trvl_pkg::t_coord              w_x;
    trvl_pkg::t_coord              w_y;
    trvl_pkg::t_coord              w_z;
    logic [trvl_pkg::EXP_W-1:0]    w_exp;
    logic [trvl_pkg::FAULT_W-1:0]  w_fault;

    // Front end: classify the address (bad root before bad depth) and hold
    // it in a two-entry queue so a new transfer lands while the engine runs.
    trvl_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_root      (i_s_axis_tdata[5:0]),
        .i_depth     (i_s_axis_tdata[11:6]),
        .i_path      ({i_s_axis_tdata[63:12], i_s_axis_tdata[127:64]}),
        .o_job       (w_job),
        .o_job_valid (w_job_valid),
        .i_job_pop   (w_job_pop)
    );

    // Back end: walk the path one level per cycle, then reduce each corner
    // to its lowest dyadic form and hand it to the output register.
    trvl_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job),
        .i_job_valid (w_job_valid),
        .o_job_pop   (w_job_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_corner    (w_corner),
        .o_x         (w_x),
        .o_y         (w_y),
        .o_z         (w_z),
        .o_exp       (w_exp),
        .o_fault     (w_fault),
        .o_last      (o_m_axis_tlast)
    );

    // pack the result transfer
    assign o_m_axis_tdata = {2'b00, w_exp, w_z, w_y, w_x};
    assign o_m_axis_tuser = {w_fault, w_corner};

`ifndef ASSERT_OFF
    // a fault result is alone: corner 0 and last
    a_fault_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[3:2] != 2'd0)
        |-> o_m_axis_tlast && (o_m_axis_tuser[1:0] == 2'd0))
        else $error("fault result not a single last transfer");

    // last only closes corner 3 or a fault
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast
        |-> (o_m_axis_tuser[1:0] == 2'd3) || (o_m_axis_tuser[3:2] != 2'd0))
        else $error("last on a corner other than 3");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid right after reset");
`endif

endmodule
